// ===== rtl/lc2k_pkg.sv =====
// Shared types, codes and sizes for the LC-2K instruction executor.
package lc2k_pkg;

	localparam int MEM_WORDS_DEF = 65536;
	localparam int NUM_REGS      = 8;
	localparam int REG_IDX_W     = 3;
	localparam int WORD_W        = 32;
	localparam int ADDR_PORT_W   = 16;
	localparam int WRAP_W        = 34;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_STEP  = 2'd1,
		REQ_RDMEM = 2'd2,
		REQ_RDREG = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_NOR  = 3'd1,
		OP_LW   = 3'd2,
		OP_SW   = 3'd3,
		OP_BEQ  = 3'd4,
		OP_JALR = 3'd5,
		OP_HALT = 3'd6,
		OP_NOOP = 3'd7
	} opcode_t;

	localparam logic [1:0] ST_RUN     = 2'd0;
	localparam logic [1:0] ST_HALT    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	typedef struct packed {
		logic                 re;
		logic [REG_IDX_W-1:0] ra;
		logic [REG_IDX_W-1:0] rb;
		logic                 we;
		logic [REG_IDX_W-1:0] wa;
		logic [WORD_W-1:0]    wd;
	} rf_req_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

// ===== rtl/lc2k_wordmem.sv =====
// Single-port synchronous word memory with registered read data.
module lc2k_wordmem import lc2k_pkg::*; #(
	parameter int WORDS = MEM_WORDS_DEF,
	localparam int AW = $clog2(WORDS)
) (
	input  logic              clk,
	input  mem_ctl_t          ctl,
	input  logic [AW-1:0]     addr,
	input  logic [WORD_W-1:0] wdata,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lc2k_regfile.sv =====
// Eight-entry register file, two registered read ports, reset to zero by valid bits.
module lc2k_regfile import lc2k_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rf_req_t           req,
	output logic [WORD_W-1:0] a_data,
	output logic [WORD_W-1:0] b_data
);

	logic [WORD_W-1:0]   regs [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [WORD_W-1:0]   a_q;
	logic [WORD_W-1:0]   b_q;
	logic                av_q;
	logic                bv_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			regs[req.wa] <= req.wd;
		end
		if (req.re) begin
			a_q <= regs[req.ra];
			b_q <= regs[req.rb];
		end
	end

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			av_q    <= 1'b0;
			bv_q    <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.wa] <= 1'b1;
			end
			if (req.re) begin
				av_q <= valid_q[req.ra];
				bv_q <= valid_q[req.rb];
			end
		end
	end

	assign a_data = av_q ? a_q : '0;
	assign b_data = bv_q ? b_q : '0;

endmodule

// ===== rtl/lc2k_wrap.sv =====
// Address wrap unit: nonnegative remainder of a signed value by the memory size.
module lc2k_wrap import lc2k_pkg::*; #(
	parameter int WORDS = MEM_WORDS_DEF,
	localparam int AW = $clog2(WORDS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WRAP_W-1:0] value,
	output logic              done,
	output logic [AW-1:0]     result
);

	localparam bit POW2 = (WORDS == (1 << AW));

	if (POW2) begin : g_mask
		logic          done_q;
		logic [AW-1:0] res_q;

		// With a power-of-two size the remainder is just the low bits.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
				res_q  <= '0;
			end else begin
				done_q <= start;
				if (start) begin
					res_q <= value[AW-1:0];
				end
			end
		end

		assign done   = done_q;
		assign result = res_q;
	end else begin : g_recip
		localparam int SH = AW - 1;
		localparam int QW = WRAP_W - SH;
		localparam logic [QW-1:0]     MU_L   = QW'((64'd1 << WRAP_W) / WORDS);
		localparam logic [AW-1:0]     MOD_A  = AW'(WORDS);
		localparam logic [AW+2:0]     MOD_L  = (AW + 3)'(WORDS);
		localparam logic [AW+2:0]     MOD2_L = (AW + 3)'(2 * WORDS);
		localparam logic [WRAP_W:0]   BIAS_L = (WRAP_W + 1)'((64'd1 << (WRAP_W - 1)) % WORDS);

		logic [WRAP_W-1:0] ubias;
		logic [WRAP_W-1:0] u_s1;
		logic [2*QW-1:0]   prod_s1;
		logic              v_s1;
		logic [WRAP_W-1:0] u_s2;
		logic [WRAP_W:0]   qm_s2;
		logic              v_s2;
		logic [AW+2:0]     t_s3;
		logic              v_s3;
		logic              done_q;
		logic [AW-1:0]     res_q;
		logic [QW-1:0]     q_est;
		logic [WRAP_W:0]   diff;
		logic [AW+2:0]     r_fin;

		// The value is biased by 2^33 so that it is unsigned. A reciprocal
		// multiply estimates the quotient to within two, the bias remainder is
		// taken off with the product, and one compare and add or subtract
		// brings the remainder into range.
		assign ubias = {~value[WRAP_W-1], value[WRAP_W-2:0]};
		assign q_est = prod_s1[2*QW-1:QW];
		assign diff  = {1'b0, u_s2} - qm_s2 - BIAS_L;
		assign r_fin = t_s3[AW+2] ? (t_s3 + MOD_L)
		             : (t_s3 >= MOD2_L) ? (t_s3 - MOD2_L)
		             : (t_s3 >= MOD_L) ? (t_s3 - MOD_L) : t_s3;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				u_s1    <= '0;
				prod_s1 <= '0;
				v_s1    <= 1'b0;
				u_s2    <= '0;
				qm_s2   <= '0;
				v_s2    <= 1'b0;
				t_s3    <= '0;
				v_s3    <= 1'b0;
				done_q  <= 1'b0;
				res_q   <= '0;
			end else begin
				v_s1   <= start;
				v_s2   <= v_s1;
				v_s3   <= v_s2;
				done_q <= v_s3;
				if (start) begin
					u_s1    <= ubias;
					prod_s1 <= {{QW{1'b0}}, ubias[WRAP_W-1:SH]} * {{QW{1'b0}}, MU_L};
				end
				if (v_s1) begin
					u_s2  <= u_s1;
					qm_s2 <= {{(AW + 1){1'b0}}, q_est} * {{(QW + 1){1'b0}}, MOD_A};
				end
				if (v_s2) begin
					t_s3 <= diff[AW+2:0];
				end
				if (v_s3) begin
					res_q <= r_fin[AW-1:0];
				end
			end
		end

		assign done   = done_q;
		assign result = res_q;
	end

endmodule

// ===== rtl/lc2k_instruction_executor_core.sv =====
// Top level of the LC-2K instruction executor: request sequencer and machine state.
//
//   Channel   Signals                                        Direction
//   request   in_valid/in_ready, req_type, address,          in
//             write_data
//   result    out_valid/out_ready, program_counter,          out
//             run_status, executed_count, read_data
//
// Loads, memory reads, lw, sw, taken beq and a jalr not into its own link pass their
// address through the wrap unit; a step on a stopped machine only reports the state.
// Fetch and data share the one memory port. With a MEM_WORDS that is not a power of two
// the wrap unit uses a reciprocal multiply in place of a mask.
// A one-entry request buffer takes the next transfer while an item is worked on; a full
// result register with out_ready low holds the sequencer. Reset clears all but memory.
module lc2k_instruction_executor_core import lc2k_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               req_type,
	input  logic [ADDR_PORT_W-1:0]   address,
	input  logic signed [WORD_W-1:0] write_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ADDR_PORT_W-1:0]   program_counter,
	output logic [1:0]               run_status,
	output logic [WORD_W-1:0]        executed_count,
	output logic signed [WORD_W-1:0] read_data
);

	localparam int ADDR_W = $clog2(MEM_WORDS);
	localparam logic [ADDR_W:0] MEM_END = (ADDR_W + 1)'(MEM_WORDS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REGRD,
		S_DECODE,
		S_EXEC,
		S_WRAP,
		S_MEMRD,
		S_LWWB,
		S_DONE
	} state_t;

	state_t                   state_q;
	logic                     ibuf_v_q;
	req_t                     ibuf_req_q;
	logic [ADDR_PORT_W-1:0]   ibuf_addr_q;
	logic [WORD_W-1:0]        ibuf_wdata_q;
	req_t                     cur_req_q;
	logic [WORD_W-1:0]        cur_wdata_q;
	logic [ADDR_W-1:0]        pc_q;
	logic [1:0]               status_q;
	logic [WORD_W-1:0]        count_q;
	logic [WORD_W-1:0]        inst_q;
	logic [WORD_W-1:0]        bval_q;
	logic [WORD_W-1:0]        rdata_q;
	logic                     out_valid_q;
	logic [ADDR_PORT_W-1:0]   out_pc_q;
	logic [1:0]               out_status_q;
	logic [WORD_W-1:0]        out_count_q;
	logic [WORD_W-1:0]        out_rdata_q;

	mem_ctl_t                 mem_ctl;
	logic [ADDR_W-1:0]        mem_addr;
	logic [WORD_W-1:0]        mem_wdata;
	logic [WORD_W-1:0]        mem_rdata;
	rf_req_t                  rf_req;
	logic [WORD_W-1:0]        rf_a;
	logic [WORD_W-1:0]        rf_b;
	logic                     wrap_start;
	logic [WRAP_W-1:0]        wrap_value;
	logic                     wrap_done;
	logic [ADDR_W-1:0]        wrap_result;

	opcode_t                  op;
	logic [REG_IDX_W-1:0]     ra_i;
	logic [REG_IDX_W-1:0]     rb_i;
	logic [REG_IDX_W-1:0]     rd_i;
	logic                     illegal;
	logic [ADDR_W:0]          pc_p1;
	logic [ADDR_W-1:0]        pc_inc;
	logic [WORD_W-1:0]        count_inc;
	logic [WRAP_W-1:0]        off34;
	logic [WRAP_W-1:0]        a34;
	logic [WRAP_W-1:0]        data_addr;
	logic [WRAP_W-1:0]        beq_target;

	lc2k_wordmem #(.WORDS(MEM_WORDS)) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	lc2k_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rf_req),
		.a_data (rf_a),
		.b_data (rf_b)
	);

	lc2k_wrap #(.WORDS(MEM_WORDS)) u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wrap_start),
		.value  (wrap_value),
		.done   (wrap_done),
		.result (wrap_result)
	);

	assign op      = opcode_t'(inst_q[24:22]);
	assign ra_i    = inst_q[21:19];
	assign rb_i    = inst_q[18:16];
	assign rd_i    = inst_q[REG_IDX_W-1:0];
	assign illegal = |inst_q[31:25];

	assign pc_p1      = {1'b0, pc_q} + 1'b1;
	assign pc_inc     = (pc_p1 == MEM_END) ? '0 : pc_p1[ADDR_W-1:0];
	assign count_inc  = (count_q == '1) ? count_q : count_q + 1'b1;
	assign off34      = {{(WRAP_W - 16){inst_q[15]}}, inst_q[15:0]};
	assign a34        = {{(WRAP_W - WORD_W){rf_a[WORD_W-1]}}, rf_a};
	assign data_addr  = a34 + off34;
	assign beq_target = WRAP_W'(pc_q) + WRAP_W'(1) + off34;

	// The sequencer holds one item at a time, so a register file or memory
	// read never overlaps a write to the same entry.
	always_comb begin
		mem_ctl    = '0;
		mem_addr   = pc_q;
		mem_wdata  = cur_wdata_q;
		rf_req     = '0;
		wrap_start = 1'b0;
		wrap_value = '0;
		case (state_q)
			S_IDLE: begin
				if (ibuf_v_q) begin
					case (ibuf_req_q)
						REQ_LOAD, REQ_RDMEM: begin
							wrap_start = 1'b1;
							wrap_value = WRAP_W'(ibuf_addr_q);
						end
						REQ_STEP: begin
							mem_ctl.re = (status_q == ST_RUN);
						end
						REQ_RDREG: begin
							rf_req.re = 1'b1;
							rf_req.ra = ibuf_addr_q[REG_IDX_W-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			S_DECODE: begin
				rf_req.re = 1'b1;
				rf_req.ra = mem_rdata[21:19];
				rf_req.rb = mem_rdata[18:16];
			end
			S_EXEC: begin
				if (!illegal) begin
					case (op)
						OP_ADD: begin
							rf_req.we = 1'b1;
							rf_req.wa = rd_i;
							rf_req.wd = rf_a + rf_b;
						end
						OP_NOR: begin
							rf_req.we = 1'b1;
							rf_req.wa = rd_i;
							rf_req.wd = ~(rf_a | rf_b);
						end
						OP_LW, OP_SW: begin
							wrap_start = 1'b1;
							wrap_value = data_addr;
						end
						OP_BEQ: begin
							wrap_start = (rf_a == rf_b);
							wrap_value = beq_target;
						end
						OP_JALR: begin
							rf_req.we  = 1'b1;
							rf_req.wa  = rb_i;
							rf_req.wd  = WORD_W'(pc_inc);
							wrap_start = (ra_i != rb_i);
							wrap_value = a34;
						end
						default: begin
						end
					endcase
				end
			end
			S_WRAP: begin
				mem_addr = wrap_result;
				if (wrap_done) begin
					case (cur_req_q)
						REQ_LOAD:  mem_ctl.we = 1'b1;
						REQ_RDMEM: mem_ctl.re = 1'b1;
						REQ_STEP: begin
							mem_ctl.re = (op == OP_LW);
							mem_ctl.we = (op == OP_SW);
							if (op == OP_SW) begin
								mem_wdata = bval_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_LWWB: begin
				rf_req.we = 1'b1;
				rf_req.wa = rb_i;
				rf_req.wd = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ibuf_v_q     <= 1'b0;
			ibuf_req_q   <= REQ_LOAD;
			ibuf_addr_q  <= '0;
			ibuf_wdata_q <= '0;
			cur_req_q    <= REQ_LOAD;
			cur_wdata_q  <= '0;
			pc_q         <= '0;
			status_q     <= ST_RUN;
			count_q      <= '0;
			inst_q       <= '0;
			bval_q       <= '0;
			rdata_q      <= '0;
			out_valid_q  <= 1'b0;
			out_pc_q     <= '0;
			out_status_q <= ST_RUN;
			out_count_q  <= '0;
			out_rdata_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				ibuf_v_q     <= 1'b1;
				ibuf_req_q   <= req_t'(req_type);
				ibuf_addr_q  <= address;
				ibuf_wdata_q <= write_data;
			end
			// In S_DONE the result register is refilled in the cycle it drains.
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ibuf_v_q) begin
						ibuf_v_q    <= 1'b0;
						cur_req_q   <= ibuf_req_q;
						cur_wdata_q <= ibuf_wdata_q;
						rdata_q     <= '0;
						case (ibuf_req_q)
							REQ_LOAD, REQ_RDMEM: state_q <= S_WRAP;
							REQ_STEP: begin
								state_q <= (status_q == ST_RUN) ? S_DECODE : S_DONE;
							end
							REQ_RDREG: state_q <= S_REGRD;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_REGRD: begin
					rdata_q <= rf_a;
					state_q <= S_DONE;
				end
				S_DECODE: begin
					inst_q  <= mem_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (illegal) begin
						status_q <= ST_ILLEGAL;
						state_q  <= S_DONE;
					end else begin
						case (op)
							OP_ADD, OP_NOR, OP_NOOP: begin
								pc_q    <= pc_inc;
								count_q <= count_inc;
								state_q <= S_DONE;
							end
							OP_HALT: begin
								pc_q     <= pc_inc;
								count_q  <= count_inc;
								status_q <= ST_HALT;
								state_q  <= S_DONE;
							end
							OP_LW, OP_SW: begin
								bval_q  <= rf_b;
								state_q <= S_WRAP;
							end
							OP_BEQ: begin
								if (rf_a == rf_b) begin
									state_q <= S_WRAP;
								end else begin
									pc_q    <= pc_inc;
									count_q <= count_inc;
									state_q <= S_DONE;
								end
							end
							OP_JALR: begin
								// When both fields name one register the link
								// is written first, so the jump lands on pc+1.
								if (ra_i == rb_i) begin
									pc_q    <= pc_inc;
									count_q <= count_inc;
									state_q <= S_DONE;
								end else begin
									state_q <= S_WRAP;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_WRAP: begin
					if (wrap_done) begin
						case (cur_req_q)
							REQ_LOAD:  state_q <= S_DONE;
							REQ_RDMEM: state_q <= S_MEMRD;
							REQ_STEP: begin
								case (op)
									OP_LW: state_q <= S_LWWB;
									OP_SW: begin
										pc_q    <= pc_inc;
										count_q <= count_inc;
										state_q <= S_DONE;
									end
									default: begin
										pc_q    <= wrap_result;
										count_q <= count_inc;
										state_q <= S_DONE;
									end
								endcase
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_MEMRD: begin
					rdata_q <= mem_rdata;
					state_q <= S_DONE;
				end
				S_LWWB: begin
					pc_q    <= pc_inc;
					count_q <= count_inc;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_pc_q     <= ADDR_PORT_W'(pc_q);
						out_status_q <= status_q;
						out_count_q  <= count_q;
						out_rdata_q  <= rdata_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready        = !ibuf_v_q;
	assign out_valid       = out_valid_q;
	assign program_counter = out_pc_q;
	assign run_status      = out_status_q;
	assign executed_count  = out_count_q;
	assign read_data       = out_rdata_q;

endmodule

// ===== rtl/lc2k_checker.sv =====
// Port-level assertions for the LC-2K instruction executor, bound to the top level.
module lc2k_checker import lc2k_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [ADDR_PORT_W-1:0] program_counter,
	input logic [1:0]             run_status,
	input logic [WORD_W-1:0]      executed_count
);

	logic                   out_xfer;
	logic                   seen_q;
	logic [1:0]             prev_status_q;
	logic [WORD_W-1:0]      prev_count_q;
	logic [ADDR_PORT_W-1:0] prev_pc_q;

	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			prev_status_q <= ST_RUN;
			prev_count_q  <= '0;
			prev_pc_q     <= '0;
		end else if (out_xfer) begin
			seen_q        <= 1'b1;
			prev_status_q <= run_status;
			prev_count_q  <= executed_count;
			prev_pc_q     <= program_counter;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(program_counter)
			&& $stable(executed_count) && $stable(run_status))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_status == ST_RUN || run_status == ST_HALT
			|| run_status == ST_ILLEGAL)
		else $error("run status outside its codes");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_q && prev_status_q != ST_RUN |->
			run_status == prev_status_q && executed_count == prev_count_q
			&& program_counter == prev_pc_q)
		else $error("stopped machine changed state");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_q |-> executed_count >= prev_count_q)
		else $error("instruction count went backward");

endmodule

bind lc2k_instruction_executor_core lc2k_checker u_lc2k_checker (.*);

// ===== test/lc2k_instruction_executor_core_tb.sv =====
// Self-checking testbench for the LC-2K instruction executor core.
`timescale 1ns / 100ps

module lc2k_instruction_executor_core_tb;
	import lc2k_pkg::*;

	localparam int ITEM_TARGET = 800;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic [15:0] pc;
		logic [1:0]  status;
		logic [31:0] count;
		logic [31:0] rdata;
	} core_result_t;

	typedef struct {
		req_t         kind;
		logic [15:0]  a;
		logic [31:0]  d;
		bit           typed;
		core_result_t want;
	} bringup_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               req_type;
	logic [15:0]              address;
	logic signed [31:0]       write_data;
	logic                     out_valid;
	logic                     out_ready;
	logic [15:0]              program_counter;
	logic [1:0]               run_status;
	logic [31:0]              executed_count;
	logic signed [31:0]       read_data;

	// Mirror of the machine, advanced when a request is queued for transfer.
	logic [31:0]  mem_img [0:65535];
	bit           mem_set [0:65535];
	logic [31:0]  gpr [0:7];
	logic [15:0]  pc_q;
	logic [1:0]   status_q;
	logic [31:0]  count_q;
	logic [15:0]  stored_addrs [$];

	core_result_t pending_results [$];
	bringup_row_t bringup [$];

	int  sent;
	int  steps_sent;
	int  checked;
	int  errors;
	int  cycles;
	bit  quiet;

	lc2k_instruction_executor_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.address         (address),
		.write_data      (write_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.program_counter (program_counter),
		.run_status      (run_status),
		.executed_count  (executed_count),
		.read_data       (read_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] encode(opcode_t op, logic [2:0] ra, logic [2:0] rb,
			logic [15:0] off);
		return {7'd0, op, ra, rb, off};
	endfunction

	function automatic logic [31:0] random_instr();
		logic [2:0]  op_pick;
		logic [15:0] off;
		op_pick = 3'($urandom_range(0, 6));
		if (op_pick == 3'd6)
			op_pick = OP_NOOP;
		// Half of the offsets stay near zero so that code runs in local loops.
		if ($urandom_range(0, 1) == 0)
			off = 16'($urandom_range(0, 15)) - 16'd8;
		else
			off = 16'($urandom);
		return {7'd0, op_pick, 3'($urandom), 3'($urandom), off};
	endfunction

	function automatic core_result_t apply_request(req_t kind, logic [15:0] a, logic [31:0] d);
		core_result_t res;
		logic [31:0]  word;
		logic [2:0]   ra, rb, rd;
		logic [15:0]  off, nxt, da;
		res.rdata = '0;
		case (kind)
			REQ_LOAD: begin
				mem_img[a] = d;
				mem_set[a] = 1'b1;
				stored_addrs.push_back(a);
			end
			REQ_STEP: begin
				if (status_q == ST_RUN) begin
					word = mem_img[pc_q];
					if (word[31:25] != 7'd0) begin
						status_q = ST_ILLEGAL;
					end else begin
						ra  = word[21:19];
						rb  = word[18:16];
						rd  = word[2:0];
						off = word[15:0];
						nxt = pc_q + 16'd1;
						da  = gpr[ra][15:0] + off;
						case (opcode_t'(word[24:22]))
							OP_ADD:  gpr[rd] = gpr[ra] + gpr[rb];
							OP_NOR:  gpr[rd] = ~(gpr[ra] | gpr[rb]);
							OP_LW:   gpr[rb] = mem_img[da];
							OP_SW: begin
								mem_img[da] = gpr[rb];
								mem_set[da] = 1'b1;
								stored_addrs.push_back(da);
							end
							OP_BEQ: begin
								if (gpr[ra] == gpr[rb])
									nxt = pc_q + 16'd1 + off;
							end
							OP_JALR: begin
								// The link is written first, so regA equal to regB jumps to pc+1.
								gpr[rb] = {16'h0, pc_q + 16'd1};
								nxt = gpr[ra][15:0];
							end
							OP_HALT: status_q = ST_HALT;
							default: ;
						endcase
						pc_q = nxt;
						if (count_q != '1)
							count_q = count_q + 32'd1;
					end
				end
			end
			REQ_RDMEM: res.rdata = mem_img[a];
			default:   res.rdata = gpr[a[2:0]];
		endcase
		res.pc     = pc_q;
		res.status = status_q;
		res.count  = count_q;
		return res;
	endfunction

	task automatic send_item(input req_t kind, input logic [15:0] a, input logic [31:0] d,
			input bit typed = 1'b0, input core_result_t want = '0);
		core_result_t predicted;
		quiet = (sent >= 300 && sent < 450);
		predicted = apply_request(kind, a, d);
		pending_results.push_back(typed ? want : predicted);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 7) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		req_type   = kind;
		address    = a;
		write_data = d;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
		if (kind == REQ_STEP)
			steps_sent++;
	endtask

	// A step never fetches, or loads through lw, a word that was never written.
	task automatic step_machine();
		logic [31:0] word;
		logic [15:0] da;
		if (status_q == ST_RUN) begin
			if (!mem_set[pc_q])
				send_item(REQ_LOAD, pc_q, random_instr());
			word = mem_img[pc_q];
			da = gpr[word[21:19]][15:0] + word[15:0];
			if (word[31:25] == 7'd0 && word[24:22] == OP_LW && !mem_set[da])
				send_item(REQ_LOAD, da, $urandom);
		end
		send_item(REQ_STEP, 16'($urandom), $urandom);
	endtask

	task automatic add_row(input req_t kind, input logic [15:0] a, input logic [31:0] d,
			input bit typed = 1'b0, input core_result_t want = '0);
		bringup_row_t r;
		r.kind  = kind;
		r.a     = a;
		r.d     = d;
		r.typed = typed;
		r.want  = want;
		bringup.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		core_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no request outstanding");
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				check_field("program_counter", 32'(exp_res.pc), 32'(program_counter));
				check_field("run_status", 32'(exp_res.status), 32'(run_status));
				check_field("executed_count", exp_res.count, executed_count);
				check_field("read_data", exp_res.rdata, read_data);
			end
			checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.", cycles,
				pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: random back-pressure, plus one long hold-off that fills the core.
	initial begin
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && checked >= HOLD_AT) begin
				held = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready = quiet || ($urandom_range(0, 99) >= 7);
		end
	end

	initial begin
		int          pick;
		logic [15:0] a;
		logic [31:0] stop_word;
		bit          by_halt;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		req_type   = REQ_LOAD;
		address    = '0;
		write_data = '0;
		sent       = 0;
		steps_sent = 0;
		checked    = 0;
		errors     = 0;
		cycles     = 0;
		quiet      = 1'b0;
		foreach (gpr[i])
			gpr[i] = '0;
		foreach (mem_set[i])
			mem_set[i] = 1'b0;
		pc_q     = '0;
		status_q = ST_RUN;
		count_q  = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Bring-up: state after reset, extreme words, then a short program that
		// touches every operation but halt, both beq outcomes, wrapped data addresses and
		// a jalr that links into its own target register.
		add_row(REQ_RDREG, 16'hFFF8, 32'h0, 1'b1,
			core_result_t'{16'h0, ST_RUN, 32'd0, 32'h0});
		add_row(REQ_LOAD, 16'hFFFF, 32'h8000_0000, 1'b1,
			core_result_t'{16'h0, ST_RUN, 32'd0, 32'h0});
		add_row(REQ_LOAD, 16'h8000, 32'h7FFF_FFFF, 1'b1,
			core_result_t'{16'h0, ST_RUN, 32'd0, 32'h0});
		add_row(REQ_RDMEM, 16'hFFFF, 32'h0, 1'b1,
			core_result_t'{16'h0, ST_RUN, 32'd0, 32'h8000_0000});
		add_row(REQ_LOAD, 16'd0, encode(OP_NOR, 3'd0, 3'd0, 16'd1));
		add_row(REQ_STEP, 16'h0, 32'h0);
		add_row(REQ_LOAD, 16'd1, encode(OP_ADD, 3'd1, 3'd1, 16'd2));
		add_row(REQ_STEP, 16'hFFFF, 32'hFFFF_FFFF);
		add_row(REQ_LOAD, 16'd2, encode(OP_LW, 3'd0, 3'd3, 16'hFFFF));
		add_row(REQ_STEP, 16'h0, 32'h0);
		add_row(REQ_LOAD, 16'd3, encode(OP_ADD, 3'd3, 3'd3, 16'd7));
		add_row(REQ_STEP, 16'h0, 32'h0);
		add_row(REQ_LOAD, 16'd4, encode(OP_SW, 3'd1, 3'd3, 16'hFFFE));
		add_row(REQ_STEP, 16'h0, 32'h0);
		add_row(REQ_LOAD, 16'd5, encode(OP_BEQ, 3'd0, 3'd0, 16'd2));
		add_row(REQ_STEP, 16'h0, 32'h0);
		add_row(REQ_LOAD, 16'd8, encode(OP_BEQ, 3'd1, 3'd0, 16'hFFFF));
		add_row(REQ_STEP, 16'h0, 32'h0);
		add_row(REQ_LOAD, 16'd9, encode(OP_JALR, 3'd5, 3'd5, 16'h0));
		add_row(REQ_STEP, 16'h0, 32'h0);
		add_row(REQ_LOAD, 16'd10, encode(OP_NOOP, 3'd7, 3'd7, 16'hFFFF));
		add_row(REQ_STEP, 16'h0, 32'h0);
		add_row(REQ_LOAD, 16'd11, encode(OP_JALR, 3'd2, 3'd6, 16'h0));
		add_row(REQ_STEP, 16'h0, 32'h0);
		add_row(REQ_RDMEM, 16'hFFFD, 32'h0, 1'b1,
			core_result_t'{16'hFFFE, ST_RUN, 32'd10, 32'h8000_0000});
		add_row(REQ_RDREG, 16'h1237, 32'h0, 1'b1,
			core_result_t'{16'hFFFE, ST_RUN, 32'd10, 32'h0});
		foreach (bringup[i])
			send_item(bringup[i].kind, bringup[i].a, bringup[i].d, bringup[i].typed,
				bringup[i].want);

		// Random programs: mostly load-then-execute, with data traffic and reads mixed in.
		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				step_machine();
			end else if (pick < 62) begin
				a = pc_q + 16'($urandom_range(0, 4));
				send_item(REQ_LOAD, a, random_instr());
			end else if (pick < 72) begin
				send_item(REQ_LOAD, 16'($urandom), $urandom);
			end else if (pick < 85) begin
				a = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
				send_item(REQ_RDMEM, a, $urandom);
			end else begin
				send_item(REQ_RDREG, 16'($urandom), $urandom);
			end
		end

		// Stop the machine by halt or by an illegal opcode, then poke the frozen core.
		by_halt = $urandom_range(0, 1);
		if (by_halt)
			stop_word = encode(OP_HALT, 3'($urandom), 3'($urandom), 16'($urandom));
		else
			stop_word = {7'($urandom_range(1, 127)), 25'($urandom)};
		send_item(REQ_LOAD, pc_q, stop_word);
		send_item(REQ_STEP, 16'($urandom), $urandom);
		repeat (12) begin
			if ($urandom_range(0, 1) == 0)
				step_machine();
			else
				send_item(REQ_RDREG, 16'($urandom), $urandom);
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("Checked %0d results from %0d requests, %0d of them instruction steps.",
			checked, sent, steps_sent);
		$display("Machine retired %0d instructions and was stopped by %s at pc %h.",
			count_q, by_halt ? "halt" : "an illegal opcode", pc_q);
		if (errors == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lc2k_pkg.sv
rtl/lc2k_wordmem.sv
rtl/lc2k_regfile.sv
rtl/lc2k_wrap.sv
rtl/lc2k_instruction_executor_core.sv
rtl/lc2k_checker.sv
test/lc2k_instruction_executor_core_tb.sv
